// File: rtl/core/brs_pkg.sv
package brs_pkg;

    // map geometry
    localparam int unsigned MAP_BITS  = 65536;
    localparam int unsigned MAP_BYTES = (MAP_BITS + 7) / 8;
    localparam int unsigned ADDR_W    = (MAP_BYTES > 1) ? $clog2(MAP_BYTES) : 1;

    // beat field widths
    localparam int unsigned DATA_W  = 8;
    localparam int unsigned START_W = 16;
    localparam int unsigned COUNT_W = 17;
    localparam int unsigned IDX_W   = 13;
    localparam int unsigned END_W   = 18;   // start + count, one bit of carry

    localparam logic [DATA_W-1:0] FULL_MASK = '1;

    // command codes
    localparam logic CMD_SET  = 1'b0;
    localparam logic CMD_READ = 1'b1;

    // read response from sequencer to output stage
    typedef struct packed {
        logic              valid;
        logic [DATA_W-1:0] data;
    } rsp_t;

endpackage

// File: rtl/core/brs_ram.sv
module brs_ram #(
    parameter int unsigned DATA_W = 8,
    parameter int unsigned DEPTH  = 8192,
    parameter int unsigned ADDR_W = 13
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [DATA_W-1:0] wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [DATA_W-1:0] rdata
);

    logic [DATA_W-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // read data holds until the next read
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// File: rtl/core/brs_seq.sv
module brs_seq import brs_pkg::*; (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic               cmd,
    input  logic [START_W-1:0] start_bit,
    input  logic [COUNT_W-1:0] bit_count,
    input  logic [IDX_W-1:0]   byte_index,
    output rsp_t               rsp,
    input  logic               rsp_take,
    output logic               ram_we,
    output logic [ADDR_W-1:0]  ram_waddr,
    output logic [DATA_W-1:0]  ram_wdata,
    output logic               ram_re,
    output logic [ADDR_W-1:0]  ram_raddr,
    input  logic [DATA_W-1:0]  ram_rdata
);

    typedef enum logic [4:0] {
        S_CLR   = 5'b00001,
        S_IDLE  = 5'b00010,
        S_SET   = 5'b00100,
        S_DRAIN = 5'b01000,
        S_RD    = 5'b10000
    } state_t;

    state_t              state_reg, state_next;
    logic [ADDR_W-1:0]   clr_reg, clr_next;
    logic [ADDR_W-1:0]   cur_reg, cur_next;
    logic [ADDR_W-1:0]   lo_reg, lo_next;
    logic [ADDR_W-1:0]   hi_reg, hi_next;
    logic [DATA_W-1:0]   fmask_reg, fmask_next;
    logic [DATA_W-1:0]   lmask_reg, lmask_next;
    logic                wr_pend_reg, wr_pend_next;
    logic [ADDR_W-1:0]   wr_addr_reg, wr_addr_next;
    logic [DATA_W-1:0]   wr_mask_reg, wr_mask_next;
    logic                rd_zero_reg, rd_zero_next;

    logic                accept;
    logic                idx_ok;
    logic                start_ok;
    logic                set_live;
    logic [END_W-1:0]    end_sum;
    logic [END_W-1:0]    end_clip;
    logic [END_W-1:0]    last_bit;
    logic [DATA_W-1:0]   cur_mask;

    // range decode of the incoming set
    assign end_sum  = END_W'(start_bit) + END_W'(bit_count);
    assign start_ok = 32'(start_bit) < MAP_BITS;
    assign set_live = (bit_count != '0) && start_ok;
    assign end_clip = (32'(end_sum) > MAP_BITS) ? END_W'(MAP_BITS) : end_sum;
    assign last_bit = end_clip - END_W'(1);
    assign idx_ok   = 32'(byte_index) < MAP_BYTES;

    assign in_ready = (state_reg == S_IDLE);
    assign accept   = in_valid && in_ready;

    assign cur_mask = ((cur_reg == lo_reg) ? fmask_reg : FULL_MASK)
                    & ((cur_reg == hi_reg) ? lmask_reg : FULL_MASK);

    // memory port drive: clearing writes zeros; a set reads a byte and ORs the mask in on the cycle after
    assign ram_re    = (state_reg == S_SET) || (accept && (cmd == CMD_READ) && idx_ok);
    assign ram_raddr = (state_reg == S_SET) ? cur_reg : ADDR_W'(byte_index);
    assign ram_we    = (state_reg == S_CLR) || wr_pend_reg;
    assign ram_waddr = (state_reg == S_CLR) ? clr_reg : wr_addr_reg;
    assign ram_wdata = (state_reg == S_CLR) ? '0 : (ram_rdata | wr_mask_reg);

    assign rsp.valid = (state_reg == S_RD);
    assign rsp.data  = rd_zero_reg ? '0 : ram_rdata;

    always_comb
    begin
        state_next   = state_reg;
        clr_next     = clr_reg;
        cur_next     = cur_reg;
        lo_next      = lo_reg;
        hi_next      = hi_reg;
        fmask_next   = fmask_reg;
        lmask_next   = lmask_reg;
        rd_zero_next = rd_zero_reg;
        wr_pend_next = (state_reg == S_SET);
        wr_addr_next = cur_reg;
        wr_mask_next = cur_mask;

        case (state_reg)
            S_CLR:
            begin
                clr_next = clr_reg + ADDR_W'(1);
                if (clr_reg == ADDR_W'(MAP_BYTES - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (accept)
                begin
                    if (cmd == CMD_READ)
                    begin
                        rd_zero_next = !idx_ok;
                        state_next   = S_RD;
                    end
                    else if (set_live)
                    begin
                        lo_next    = ADDR_W'(start_bit >> 3);
                        cur_next   = ADDR_W'(start_bit >> 3);
                        hi_next    = ADDR_W'(last_bit >> 3);
                        fmask_next = FULL_MASK << start_bit[2:0];
                        lmask_next = FULL_MASK >> (3'd0 - end_clip[2:0]);
                        state_next = S_SET;
                    end
                end
            end
            S_SET:
            begin
                cur_next = cur_reg + ADDR_W'(1);
                if (cur_reg == hi_reg)
                begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN:
            begin
                // last write lands here, before any new read is issued
                state_next = S_IDLE;
            end
            S_RD:
            begin
                if (rsp_take)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_CLR;
            clr_reg     <= '0;
            wr_pend_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            clr_reg     <= clr_next;
            wr_pend_reg <= wr_pend_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg     <= cur_next;
        lo_reg      <= lo_next;
        hi_reg      <= hi_next;
        fmask_reg   <= fmask_next;
        lmask_reg   <= lmask_next;
        wr_addr_reg <= wr_addr_next;
        wr_mask_reg <= wr_mask_next;
        rd_zero_reg <= rd_zero_next;
    end

endmodule

// File: rtl/core/bitmap_range_set.sv
// A read passes the RAM read register, then the output register (when free), to read_data.
// A set walks its map bytes, then a drain state; a zero-count set goes straight back to idle.
// Throughput is bounded by the single RAM port pair: one byte read-modify-write per cycle.
// Reset: rst_n is asynchronous, active low. After release a clearing pass zeroes the map,
// one byte per cycle across all MAP_BYTES (8192) bytes, with in_ready held low throughout.
module bitmap_range_set import brs_pkg::*; (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic               cmd,
    input  logic [START_W-1:0] start_bit,
    input  logic [COUNT_W-1:0] bit_count,
    input  logic [IDX_W-1:0]   byte_index,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [DATA_W-1:0]  read_data
);

    // sequencer <-> map RAM
    logic              ram_we;
    logic [ADDR_W-1:0] ram_waddr;
    logic [DATA_W-1:0] ram_wdata;
    logic              ram_re;
    logic [ADDR_W-1:0] ram_raddr;
    logic [DATA_W-1:0] ram_rdata;

    rsp_t              rsp;
    logic              rsp_take;

    logic              out_valid_reg, out_valid_next;
    logic [DATA_W-1:0] read_data_reg, read_data_next;

    // Sequencer: clearing pass, byte walk for sets, single-byte reads.
    brs_seq u_seq (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .cmd        (cmd),
        .start_bit  (start_bit),
        .bit_count  (bit_count),
        .byte_index (byte_index),
        .rsp        (rsp),
        .rsp_take   (rsp_take),
        .ram_we     (ram_we),
        .ram_waddr  (ram_waddr),
        .ram_wdata  (ram_wdata),
        .ram_re     (ram_re),
        .ram_raddr  (ram_raddr),
        .ram_rdata  (ram_rdata)
    );

    // Map store: one byte per entry, registered read.
    brs_ram #(
        .DATA_W (DATA_W),
        .DEPTH  (MAP_BYTES),
        .ADDR_W (ADDR_W)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Output register: decouples the result beat from the sequencer so a
    // waiting result does not stop the next command being taken.
    assign rsp_take = rsp.valid && (!out_valid_reg || out_ready);

    always_comb
    begin
        out_valid_next = out_valid_reg;
        read_data_next = read_data_reg;
        if (rsp_take)
        begin
            out_valid_next = 1'b1;
            read_data_next = rsp.data;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        read_data_reg <= read_data_next;
    end

    assign out_valid = out_valid_reg;
    assign read_data = read_data_reg;

endmodule

// File: rtl/core/brs_chk.sv
module brs_chk import brs_pkg::*; (
    input logic               clk,
    input logic               rst_n,
    input logic               in_valid,
    input logic               in_ready,
    input logic               cmd,
    input logic [START_W-1:0] start_bit,
    input logic [COUNT_W-1:0] bit_count,
    input logic               out_valid,
    input logic               out_ready,
    input logic [DATA_W-1:0]  read_data
);

    // stalled result beat holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(read_data))
        else $error("result beat dropped or changed under stall");

    // a live set leaves in_ready low in the cycle after it is accepted
    a_set_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && (cmd == CMD_SET) && (bit_count != '0)
            && (32'(start_bit) < MAP_BITS) |=> !in_ready)
        else $error("set beat did not start a byte walk");

    // a read is never turned round in the accept cycle
    a_read_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && (cmd == CMD_READ) |=> !in_ready)
        else $error("read beat not held for RAM latency");

    // results only appear out of the read wait, when input is closed
    a_out_src: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(!in_ready))
        else $error("result beat without a pending read");

endmodule

bind bitmap_range_set brs_chk u_brs_chk (.*);

// File: sim/bitmap_read_checker.sv
`timescale 1ns / 100ps

module bitmap_read_checker import brs_pkg::*; (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic               in_ready,
    input  logic               cmd,
    input  logic [START_W-1:0] start_bit,
    input  logic [COUNT_W-1:0] bit_count,
    input  logic [IDX_W-1:0]   byte_index,
    input  logic               out_valid,
    input  logic               out_ready,
    input  logic [DATA_W-1:0]  read_data,
    output int                 mismatches,
    output int                 reads_pending,
    output int                 reads_checked,
    output int                 sets_seen
);

    // shadow copy of the map, plus the bytes owed to the output channel
    logic [DATA_W-1:0] shadow_map [MAP_BYTES];
    logic [DATA_W-1:0] owed_bytes [$];
    logic [IDX_W-1:0]  owed_index [$];

    // OR ones into [first, first + count), clipped at the top of the map
    task automatic mark_range(input logic [START_W-1:0] first, input logic [COUNT_W-1:0] count);
        int unsigned       stop;
        int unsigned       lo_byte;
        int unsigned       hi_byte;
        int unsigned       b;
        logic [DATA_W-1:0] mask;
        if (count == 0 || first >= MAP_BITS)
            return;
        stop = first + count;
        if (stop > MAP_BITS)
            stop = MAP_BITS;
        lo_byte = first >> 3;
        hi_byte = (stop - 1) >> 3;
        for (b = lo_byte; b <= hi_byte; b++)
        begin
            mask = FULL_MASK;
            if (b == lo_byte)
                mask &= FULL_MASK << first[2:0];
            if (b == hi_byte)
                mask &= FULL_MASK >> ((8 - (stop & 7)) & 7);
            if (b < MAP_BYTES)
                shadow_map[b] |= mask;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            foreach (shadow_map[i])
                shadow_map[i] = '0;
            owed_bytes.delete();
            owed_index.delete();
            mismatches    = 0;
            reads_checked = 0;
            sets_seen     = 0;
        end
        else
        begin
            // retire first: a read accepted this edge cannot already be due
            if (out_valid && out_ready)
            begin
                if (owed_bytes.size() == 0)
                begin
                    $error("read_data: beat with no read outstanding, got %02h", read_data);
                    mismatches++;
                end
                else
                begin
                    reads_checked++;
                    if (read_data !== owed_bytes[0])
                    begin
                        $error("read_data: byte %0d expected %02h, got %02h",
                               owed_index[0], owed_bytes[0], read_data);
                        mismatches++;
                    end
                    void'(owed_bytes.pop_front());
                    void'(owed_index.pop_front());
                end
            end
            if (in_valid && in_ready)
            begin
                if (cmd == CMD_SET)
                begin
                    mark_range(start_bit, bit_count);
                    sets_seen++;
                end
                else
                begin
                    owed_bytes.push_back((byte_index < MAP_BYTES) ? shadow_map[byte_index] : '0);
                    owed_index.push_back(byte_index);
                end
            end
        end
        reads_pending = owed_bytes.size();
    end

endmodule

// File: sim/tb_bitmap_range_set.sv
`timescale 1ns / 100ps

// Stimulus and verdict for bitmap_range_set. The checker beside the DUT
// keeps its own map and scores every read beat; this module drives and reports.
module tb_bitmap_range_set;
    import brs_pkg::*;

    localparam int PHASE_BEATS  = 258;     // four phases, at least 1032 random beats
    // quiet-cycle budget: clearing pass (8192 bytes) or the longest set issued
    // (up to 128 bytes) plus a stalled receiver, with ample margin
    localparam int STALL_LIMIT  = 40000;
    localparam int DRAIN_CYCLES = 20;

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_ready;
    logic               cmd;
    logic [START_W-1:0] start_bit;
    logic [COUNT_W-1:0] bit_count;
    logic [IDX_W-1:0]   byte_index;
    logic               out_valid;
    logic               out_ready;
    logic [DATA_W-1:0]  read_data;

    int mismatches;
    int reads_pending;
    int reads_checked;
    int sets_seen;

    int unsigned idle_pct  = 0;    // chance, per cycle, the sender holds off
    int unsigned stall_pct = 0;    // chance, per cycle, the receiver stalls
    int          beats_sent = 0;
    int          quiet_cycles = 0;

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    bitmap_range_set dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .cmd        (cmd),
        .start_bit  (start_bit),
        .bit_count  (bit_count),
        .byte_index (byte_index),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .read_data  (read_data)
    );

    bitmap_read_checker checker_i (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .cmd           (cmd),
        .start_bit     (start_bit),
        .bit_count     (bit_count),
        .byte_index    (byte_index),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .read_data     (read_data),
        .mismatches    (mismatches),
        .reads_pending (reads_pending),
        .reads_checked (reads_checked),
        .sets_seen     (sets_seen)
    );

    // Receiver: ready redrawn every falling edge from the current stall rate.
    initial
    begin
        out_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            out_ready = ($urandom_range(99) >= stall_pct);
        end
    end

    // Watchdog: any cycle without a handshake on either channel counts.
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
    end

    // One beat, entered and left at a falling edge. Idle gaps come first,
    // so valid never drops once raised; payload is held until accepted.
    task automatic send_beat(input logic c, input logic [START_W-1:0] s,
                             input logic [COUNT_W-1:0] n, input logic [IDX_W-1:0] idx);
        while ($urandom_range(99) < idle_pct)
        begin
            in_valid = 1'b0;
            @(negedge clk);
        end
        in_valid   = 1'b1;
        cmd        = c;
        start_bit  = s;
        bit_count  = n;
        byte_index = idx;
        do
            @(posedge clk);
        while (!in_ready);
        @(negedge clk);
        beats_sent++;
    endtask

    // unused fields carry noise so every payload bit toggles
    task automatic send_set(input logic [START_W-1:0] s, input logic [COUNT_W-1:0] n);
        send_beat(CMD_SET, s, n, IDX_W'($urandom));
    endtask

    task automatic send_read(input int unsigned idx);
        send_beat(CMD_READ, START_W'($urandom), COUNT_W'($urandom_range(65536)), IDX_W'(idx));
    endtask

    // Mostly short ranges so the map stays sparse and partial masks show up.
    function automatic logic [COUNT_W-1:0] pick_count();
        int unsigned roll;
        roll = $urandom_range(99);
        if (roll < 75)
            return COUNT_W'($urandom_range(16));
        else if (roll < 93)
            return COUNT_W'($urandom_range(96, 17));
        else
            return COUNT_W'($urandom_range(512, 97));
    endfunction

    // A set followed by reads of its edge bytes, their neighbours or bytes in between.
    task automatic range_then_reads();
        logic [START_W-1:0] s;
        logic [COUNT_W-1:0] n;
        int unsigned        stop;
        int                 lo_b;
        int                 hi_b;
        int                 pick;
        int unsigned        reads;
        if ($urandom_range(99) < 3)
        begin
            // near the top with any count: may be clipped at the map end
            s = START_W'($urandom_range(65535, 64512));
            n = COUNT_W'($urandom_range(65536));
        end
        else
        begin
            s = START_W'($urandom);
            n = pick_count();
        end
        send_set(s, n);
        stop = s + n;
        if (stop > MAP_BITS)
            stop = MAP_BITS;
        lo_b  = s >> 3;
        hi_b  = (n == 0) ? lo_b : int'((stop - 1) >> 3);
        reads = $urandom_range(4, 1);
        repeat (reads)
        begin
            case ($urandom_range(4))
                0:       pick = lo_b - 1;
                1:       pick = lo_b;
                2:       pick = hi_b;
                3:       pick = hi_b + 1;
                default: pick = $urandom_range(hi_b, lo_b);
            endcase
            if (pick < 0)
                pick = 0;
            if (pick > int'(MAP_BYTES) - 1)
                pick = int'(MAP_BYTES) - 1;
            send_read(pick);
        end
    endtask

    initial
    begin
        int phase;
        int target;
        int unsigned roll;

        in_valid   = 1'b0;
        cmd        = CMD_SET;
        start_bit  = '0;
        bit_count  = '0;
        byte_index = '0;
        rst_n      = 1'b0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        // the block clears its map after reset; the first beat waits on in_ready

        // Directed: fresh map, zero count, single bit, whole byte, a range
        // straddling three bytes, and ranges clipped at the top of the map.
        send_read(0);
        send_read(MAP_BYTES - 1);
        send_set(0, 0);
        send_read(0);
        send_set(3, 1);
        send_read(0);
        send_set(0, 5);
        send_read(0);
        send_set(8, 8);
        send_read(1);
        send_read(2);
        send_set(21, 13);
        send_read(2);
        send_read(3);
        send_read(4);
        send_set(65535, 65536);
        send_read(MAP_BYTES - 1);
        send_set(65520, 3);
        send_read(8190);
        send_set(65000, 65536);
        send_read(8124);
        send_read(8125);

        // Random: four flow-control phases, no idling first.
        for (phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0:       begin idle_pct = 0;  stall_pct = 0;  end
                1:       begin idle_pct = 88; stall_pct = 0;  end
                2:       begin idle_pct = 0;  stall_pct = 88; end
                default: begin idle_pct = 20; stall_pct = 20; end
            endcase
            target = beats_sent + PHASE_BEATS;
            while (beats_sent < target)
            begin
                roll = $urandom_range(99);
                if (roll < 70)
                    range_then_reads();
                else if (roll < 85)
                    send_set(START_W'($urandom), pick_count());
                else
                    send_read($urandom_range(MAP_BYTES - 1));
            end
        end
        in_valid = 1'b0;

        // drain: the watchdog catches a read that never comes back
        while (reads_pending != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Run covered %0d beats: %0d range sets and %0d reads scored,",
                 beats_sent, sets_seen, reads_checked);
        $display("over free-running, sender-idle, receiver-stall and mixed phases.");
        if (mismatches == 0 && reads_pending == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
